// ----- rtl/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfn_pkg
// Types and constants shared by the triangle face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int IDX_W   = 12;                 // vertex index width
  localparam int COORD_W = 20;                 // stored coordinate width
  localparam int EDGE_W  = COORD_W + 1;        // edge vector component
  localparam int PROD_W  = 2 * EDGE_W;         // partial cross product
  localparam int CROSS_W = PROD_W + 1;         // cross product component
  localparam int MAG_W   = CROSS_W - 1;        // cross product magnitude
  localparam int NMAG_W  = 30;                 // normalized magnitude
  localparam int LEN_W   = 2 * NMAG_W + 2;     // sum of three squares
  localparam int ROOT_W  = LEN_W / 2;          // integer square root
  localparam int QUO_W   = 15;                 // quotient bits, Q1.14 magnitude
  localparam int NORM_W  = 16;                 // signed Q1.14 output

  localparam logic [QUO_W-1:0] ONE_Q14 = 15'd16384;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_NORMAL = 1'b1;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_RD_B,
    FS_RD_C
  } fetch_state_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Component 0 is x, 1 is y, 2 is z.
  typedef coord_t [2:0] vertex_t;

  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          vertex_a;
    logic [IDX_W-1:0]          vertex_b;
    logic [IDX_W-1:0]          vertex_c;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } tfn_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     degenerate;
  } tfn_out_t;

  typedef struct packed {
    vertex_t a;
    vertex_t b;
    vertex_t c;
  } tri_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } mag_t;

  typedef struct packed {
    logic [2:0][NMAG_W-1:0] mag;
    logic [2:0]             neg;
    logic                   degen;
  } norm_t;

  typedef struct packed {
    norm_t            n;
    logic [LEN_W-1:0] len2;
  } len_t;

endpackage

// ----- rtl/tfn_fetch.sv -----
// ----------------------------------------------------------------------------
// tfn_fetch
// Vertex memory with its sequencer: writes vertices and reads three corners.
// ----------------------------------------------------------------------------
module tfn_fetch #(
  parameter int VERTEX_COUNT = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  tfn_pkg::tfn_in_t in_data,
  output logic             in_stall,
  output logic             tri_valid,
  output tfn_pkg::tri_t    tri_data
);

  localparam int AW = $clog2(VERTEX_COUNT);

  tfn_pkg::vertex_t mem [VERTEX_COUNT];

  tfn_pkg::fetch_state_t state_r, state_nxt;
  logic [tfn_pkg::IDX_W-1:0] b_idx_r, b_idx_nxt, c_idx_r, c_idx_nxt, rd_idx;
  logic [AW-1:0] addr;
  logic accept, rd_ok, wr_en, rd_zero_r, tri_valid_r, tri_valid_nxt;
  tfn_pkg::vertex_t rd_data_r, rd_vtx, wr_vtx, a_r, b_r;

  assign in_stall = !en || (state_r != tfn_pkg::FS_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    case (state_r)
      tfn_pkg::FS_RD_B: rd_idx = b_idx_r;
      tfn_pkg::FS_RD_C: rd_idx = c_idx_r;
      default:          rd_idx = in_data.vertex_a;
    endcase
  end

  assign rd_ok  = 32'(rd_idx) < 32'(VERTEX_COUNT);
  assign addr   = AW'(rd_idx);
  assign wr_en  = accept && (in_data.op == tfn_pkg::OP_WRITE) && rd_ok;
  assign wr_vtx = {in_data.pos_z, in_data.pos_y, in_data.pos_x};

  // Single port: a transaction either writes or starts the first read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_vtx;
    end
    if (en) begin
      rd_data_r <= mem[addr];
      rd_zero_r <= !rd_ok;
    end
  end

  assign rd_vtx = rd_zero_r ? '0 : rd_data_r;

  always_comb begin
    state_nxt     = state_r;
    b_idx_nxt     = b_idx_r;
    c_idx_nxt     = c_idx_r;
    tri_valid_nxt = tri_valid_r;
    if (en) begin
      tri_valid_nxt = 1'b0;
      case (state_r)
        tfn_pkg::FS_IDLE: begin
          if (accept && (in_data.op == tfn_pkg::OP_NORMAL)) begin
            state_nxt = tfn_pkg::FS_RD_B;
            b_idx_nxt = in_data.vertex_b;
            c_idx_nxt = in_data.vertex_c;
          end
        end
        tfn_pkg::FS_RD_B: state_nxt = tfn_pkg::FS_RD_C;
        tfn_pkg::FS_RD_C: begin
          state_nxt     = tfn_pkg::FS_IDLE;
          tri_valid_nxt = 1'b1;
        end
        default: state_nxt = tfn_pkg::FS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tfn_pkg::FS_IDLE;
      tri_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tri_valid_r <= tri_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_idx_r <= b_idx_nxt;
    c_idx_r <= c_idx_nxt;
    if (en && (state_r == tfn_pkg::FS_RD_B)) begin
      a_r <= rd_vtx;
    end
    if (en && (state_r == tfn_pkg::FS_RD_C)) begin
      b_r <= rd_vtx;
    end
  end

  assign tri_valid = tri_valid_r;
  assign tri_data  = '{a: a_r, b: b_r, c: rd_vtx};

endmodule

// ----- rtl/tfn_cross.sv -----
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, cross product and component magnitudes, four stages.
// ----------------------------------------------------------------------------
module tfn_cross (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          tri_valid,
  input  tfn_pkg::tri_t tri_data,
  output logic          mag_valid,
  output tfn_pkg::mag_t mag_data
);

  logic [3:0] vld_r;
  logic signed [tfn_pkg::EDGE_W-1:0]  e1_r [3];
  logic signed [tfn_pkg::EDGE_W-1:0]  e2_r [3];
  logic signed [tfn_pkg::PROD_W-1:0]  p_r  [6];
  logic signed [tfn_pkg::CROSS_W-1:0] cr_r [3];
  logic signed [tfn_pkg::CROSS_W-1:0] abs_v [3];
  tfn_pkg::mag_t mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], tri_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs_v[k] = cr_r[k][tfn_pkg::CROSS_W-1] ? -cr_r[k] : cr_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= tfn_pkg::EDGE_W'($signed(tri_data.b[k]))
                 - tfn_pkg::EDGE_W'($signed(tri_data.a[k]));
        e2_r[k] <= tfn_pkg::EDGE_W'($signed(tri_data.c[k]))
                 - tfn_pkg::EDGE_W'($signed(tri_data.a[k]));
      end
      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];
      for (int k = 0; k < 3; k++) begin
        cr_r[k] <= tfn_pkg::CROSS_W'(p_r[2*k]) - tfn_pkg::CROSS_W'(p_r[2*k+1]);
        mag_r.mag[k] <= abs_v[k][tfn_pkg::MAG_W-1:0];
        mag_r.neg[k] <= cr_r[k][tfn_pkg::CROSS_W-1];
      end
    end
  end

  assign mag_valid = vld_r[3];
  assign mag_data  = mag_r;

endmodule

// ----- rtl/tfn_scale.sv -----
// ----------------------------------------------------------------------------
// tfn_scale
// Block scaling of the magnitudes so the largest lies in [2^29, 2^30), and the squared length.
// ----------------------------------------------------------------------------
module tfn_scale (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          mag_valid,
  input  tfn_pkg::mag_t mag_data,
  output logic          len_valid,
  output tfn_pkg::len_t len_data
);

  localparam int HALF = tfn_pkg::MAG_W / 2;
  localparam int PW   = $clog2(tfn_pkg::MAG_W);
  localparam int SQ_W = 2 * tfn_pkg::NMAG_W;

  function automatic logic [PW-1:0] lead_pos(input logic [HALF-1:0] v);
    lead_pos = '0;
    for (int i = 0; i < HALF; i++) begin
      if (v[i]) begin
        lead_pos = PW'(i);
      end
    end
  endfunction

  logic [6:0] vld_r;
  tfn_pkg::mag_t ma_r, mb_r, mc_r, md_r;
  logic [tfn_pkg::MAG_W-1:0] m01_r, m_r;
  logic hi_any_r, degen_c_r, degen_d_r;
  logic [PW-1:0] hi_pos_r, lo_pos_r, pos_r;
  logic [tfn_pkg::MAG_W-1:0] shv [3];
  tfn_pkg::norm_t ne_r, nf_r, ng_r;
  logic [2:0][SQ_W-1:0] sq_r;
  logic [tfn_pkg::LEN_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], mag_valid};
    end
  end

  // Every magnitude takes the same shift, so the largest lands at bit 29.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pos_r >= PW'(tfn_pkg::NMAG_W - 1)) begin
        shv[k] = md_r.mag[k] >> (pos_r - PW'(tfn_pkg::NMAG_W - 1));
      end else begin
        shv[k] = md_r.mag[k] << (PW'(tfn_pkg::NMAG_W - 1) - pos_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= mag_data;
      m01_r <= (mag_data.mag[0] > mag_data.mag[1]) ? mag_data.mag[0] : mag_data.mag[1];
      mb_r  <= ma_r;
      m_r   <= (m01_r > ma_r.mag[2]) ? m01_r : ma_r.mag[2];
      mc_r      <= mb_r;
      hi_any_r  <= |m_r[tfn_pkg::MAG_W-1:HALF];
      hi_pos_r  <= lead_pos(m_r[tfn_pkg::MAG_W-1:HALF]);
      lo_pos_r  <= lead_pos(m_r[HALF-1:0]);
      degen_c_r <= (m_r == '0);
      md_r      <= mc_r;
      degen_d_r <= degen_c_r;
      pos_r     <= hi_any_r ? (PW'(HALF) + hi_pos_r) : lo_pos_r;
      for (int k = 0; k < 3; k++) begin
        ne_r.mag[k] <= shv[k][tfn_pkg::NMAG_W-1:0];
      end
      ne_r.neg   <= md_r.neg;
      ne_r.degen <= degen_d_r;
      nf_r       <= ne_r;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= SQ_W'(ne_r.mag[k]) * SQ_W'(ne_r.mag[k]);
      end
      ng_r  <= nf_r;
      len_r <= tfn_pkg::LEN_W'(sq_r[0]) + tfn_pkg::LEN_W'(sq_r[1])
             + tfn_pkg::LEN_W'(sq_r[2]);
    end
  end

  assign len_valid = vld_r[6];
  assign len_data  = '{n: ng_r, len2: len_r};

endmodule

// ----- rtl/tfn_root_div.sv -----
// ----------------------------------------------------------------------------
// tfn_root_div
// Pipelined square root, pipelined rounded division and the output register.
// ----------------------------------------------------------------------------
module tfn_root_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              len_valid,
  input  tfn_pkg::len_t     len_data,
  output logic              out_valid,
  output tfn_pkg::tfn_out_t out_data
);

  localparam int RW    = tfn_pkg::ROOT_W;
  localparam int QW    = tfn_pkg::QUO_W;
  localparam int REM_W = RW + 3;
  localparam int NUM_W = tfn_pkg::NMAG_W + QW;
  localparam int DR_W  = RW + 1;

  typedef struct packed {
    logic [REM_W-1:0]          rem;
    logic [RW-1:0]             root;
    logic [tfn_pkg::LEN_W-1:0] rad;
  } sq_st_t;

  typedef struct packed {
    logic [2:0][DR_W-1:0] rem;
    logic [2:0][QW-1:0]   q;
    logic [2:0][QW-1:0]   low;
    logic [RW-1:0]        s;
    logic [2:0]           neg;
    logic                 degen;
  } dv_st_t;

  // One result bit of the square root per stage.
  function automatic sq_st_t sq_step(input sq_st_t st);
    logic [REM_W-1:0] r2, trial;
    r2            = {st.rem[REM_W-3:0], st.rad[tfn_pkg::LEN_W-1 -: 2]};
    trial         = {1'b0, st.root, 2'b01};
    sq_step.rad   = st.rad << 2;
    if (r2 >= trial) begin
      sq_step.rem  = r2 - trial;
      sq_step.root = {st.root[RW-2:0], 1'b1};
    end else begin
      sq_step.rem  = r2;
      sq_step.root = {st.root[RW-2:0], 1'b0};
    end
  endfunction

  // One quotient bit per stage for each of the three components.
  function automatic dv_st_t dv_step(input dv_st_t st);
    logic [DR_W-1:0] r2;
    dv_step = st;
    for (int k = 0; k < 3; k++) begin
      r2 = {st.rem[k][DR_W-2:0], st.low[k][QW-1]};
      dv_step.low[k] = st.low[k] << 1;
      if (r2 >= DR_W'(st.s)) begin
        dv_step.rem[k] = r2 - DR_W'(st.s);
        dv_step.q[k]   = {st.q[k][QW-2:0], 1'b1};
      end else begin
        dv_step.rem[k] = r2;
        dv_step.q[k]   = {st.q[k][QW-2:0], 1'b0};
      end
    end
  endfunction

  logic [RW-1:0] sv_r;
  sq_st_t sq_r [RW];
  tfn_pkg::norm_t sn_r [RW];

  logic pv_r;
  logic [2:0][NUM_W-1:0] num_r;
  logic [RW-1:0] s_r;
  tfn_pkg::norm_t pn_r;
  dv_st_t dv_init;

  logic [QW-1:0] dvv_r;
  dv_st_t dv_r [QW];

  logic out_valid_r;
  tfn_pkg::tfn_out_t out_r;
  logic [QW-1:0] qc [3];
  logic signed [tfn_pkg::NORM_W-1:0] nv [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r        <= '0;
      pv_r        <= 1'b0;
      dvv_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      sv_r        <= {sv_r[RW-2:0], len_valid};
      pv_r        <= sv_r[RW-1];
      dvv_r       <= {dvv_r[QW-2:0], pv_r};
      out_valid_r <= dvv_r[QW-1];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_init.rem[k] = DR_W'(num_r[k][NUM_W-1:QW]);
      dv_init.low[k] = num_r[k][QW-1:0];
      dv_init.q[k]   = '0;
    end
    dv_init.s     = s_r;
    dv_init.neg   = pn_r.neg;
    dv_init.degen = pn_r.degen;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (dv_r[QW-1].q[k] > tfn_pkg::ONE_Q14) ? tfn_pkg::ONE_Q14 : dv_r[QW-1].q[k];
      if (dv_r[QW-1].degen) begin
        nv[k] = '0;
      end else if (dv_r[QW-1].neg[k]) begin
        nv[k] = -tfn_pkg::NORM_W'(qc[k]);
      end else begin
        nv[k] = tfn_pkg::NORM_W'(qc[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= sq_step('{rem: '0, root: '0, rad: len_data.len2});
      sn_r[0] <= len_data.n;
      for (int k = 1; k < RW; k++) begin
        sq_r[k] <= sq_step(sq_r[k-1]);
        sn_r[k] <= sn_r[k-1];
      end
      // Rounded quotient: (mag * 2^14 + floor(s / 2)) / s.
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= NUM_W'({sn_r[RW-1].mag[k], {(QW-1){1'b0}}})
                  + NUM_W'(sq_r[RW-1].root >> 1);
      end
      s_r     <= sq_r[RW-1].root;
      pn_r    <= sn_r[RW-1];
      dv_r[0] <= dv_step(dv_init);
      for (int k = 1; k < QW; k++) begin
        dv_r[k] <= dv_step(dv_r[k-1]);
      end
      out_r.normal_x   <= nv[0];
      out_r.normal_y   <= nv[1];
      out_r.normal_z   <= nv[2];
      out_r.degenerate <= dv_r[QW-1].degen;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/triangle_face_normal_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Vertex store with a pipelined unit-normal datapath for triangles.
// ----------------------------------------------------------------------------
// A vertex write (op 0) gives no result. A face normal (op 1) holds the
// input while its three corners are read, one at a time, from the
// single-port vertex memory, so no new item is taken until those reads are
// done; writes are accepted at one per cycle while the output is not held.
// The accepting clock edge also performs the first of the three memory
// reads; after the reads come four cross product stages, seven scaling
// stages, 31 square root stages, 16 division stages and the output register.
// A held output stalls the whole pipeline in place. The memory has no reset;
// a corner that was never written reads as undefined, and an index at or
// beyond VERTEX_COUNT reads as the origin and ignores writes.
module triangle_face_normal_unit #(
  parameter int VERTEX_COUNT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tfn_pkg::tfn_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tfn_pkg::tfn_out_t out_data
);

  logic en;
  logic tri_valid, mag_valid, len_valid;
  tfn_pkg::tri_t tri_data;
  tfn_pkg::mag_t mag_data;
  tfn_pkg::len_t len_data;

  assign en = !(out_valid && out_stall);

  tfn_fetch #(.VERTEX_COUNT(VERTEX_COUNT)) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .tri_valid (tri_valid),
    .tri_data  (tri_data)
  );

  tfn_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .tri_valid (tri_valid),
    .tri_data  (tri_data),
    .mag_valid (mag_valid),
    .mag_data  (mag_data)
  );

  tfn_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .mag_valid (mag_valid),
    .mag_data  (mag_data),
    .len_valid (len_valid),
    .len_data  (len_data)
  );

  tfn_root_div u_root_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .len_valid (len_valid),
    .len_data  (len_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/tfn_checker.sv -----
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks for the triangle face normal unit, bound to the top.
// ----------------------------------------------------------------------------
module tfn_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input tfn_pkg::tfn_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input tfn_pkg::tfn_out_t out_data
);

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The two remaining corner reads keep the input side closed.
  a_normal_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.op == tfn_pkg::OP_NORMAL)
    |=> in_stall ##1 in_stall)
    else $error("input reopened during corner reads");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate
    |-> out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid
    |-> out_data.normal_x <= 16'sd16384 && out_data.normal_x >= -16'sd16384
     && out_data.normal_y <= 16'sd16384 && out_data.normal_y >= -16'sd16384
     && out_data.normal_z <= 16'sd16384 && out_data.normal_z >= -16'sd16384)
    else $error("normal component outside Q1.14 unit range");

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (.*);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for triangle_face_normal_unit. Vertex writes and face
// normal requests are driven with random idling on both sides; a scoreboard
// keeps a shadow vertex store, predicts each normal exactly in integer
// arithmetic and compares every result transaction in order.
// ----------------------------------------------------------------------------
module tb_top;

  class normal_scoreboard;
    logic signed [tfn_pkg::COORD_W-1:0] shadow_x [4096];
    logic signed [tfn_pkg::COORD_W-1:0] shadow_y [4096];
    logic signed [tfn_pkg::COORD_W-1:0] shadow_z [4096];
    tfn_pkg::tfn_out_t expected_normals[$];
    int mismatches;

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function void note_transaction(tfn_pkg::tfn_in_t t);
      longint ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
      longint cr[3];
      longint unsigned mag[3], peak, len2, root, q;
      tfn_pkg::tfn_out_t r;
      if (t.op == tfn_pkg::OP_WRITE) begin
        shadow_x[t.vertex_a] = t.pos_x;
        shadow_y[t.vertex_a] = t.pos_y;
        shadow_z[t.vertex_a] = t.pos_z;
        return;
      end
      ax = longint'(shadow_x[t.vertex_a]);
      ay = longint'(shadow_y[t.vertex_a]);
      az = longint'(shadow_z[t.vertex_a]);
      e1x = longint'(shadow_x[t.vertex_b]) - ax;
      e1y = longint'(shadow_y[t.vertex_b]) - ay;
      e1z = longint'(shadow_z[t.vertex_b]) - az;
      e2x = longint'(shadow_x[t.vertex_c]) - ax;
      e2y = longint'(shadow_y[t.vertex_c]) - ay;
      e2z = longint'(shadow_z[t.vertex_c]) - az;
      cr[0] = e1y * e2z - e1z * e2y;
      cr[1] = e1z * e2x - e1x * e2z;
      cr[2] = e1x * e2y - e1y * e2x;
      peak = 0;
      for (int k = 0; k < 3; k++) begin
        mag[k] = (cr[k] < 0) ? $unsigned(-cr[k]) : $unsigned(cr[k]);
        if (mag[k] > peak) peak = mag[k];
      end
      r = '0;
      if (peak == 0) begin
        r.degenerate = 1'b1;
      end else begin
        while (peak >= (64'd1 << 30)) begin
          for (int k = 0; k < 3; k++) mag[k] >>= 1;
          peak >>= 1;
        end
        while (peak < (64'd1 << 29)) begin
          for (int k = 0; k < 3; k++) mag[k] <<= 1;
          peak <<= 1;
        end
        len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        root = int_sqrt(len2);
        for (int k = 0; k < 3; k++) begin
          q = (mag[k] * 64'd16384 + (root >> 1)) / root;
          if (q > 64'd16384) q = 64'd16384;
          if (cr[k] < 0) q = -q;
          case (k)
            0: r.normal_x = q[15:0];
            1: r.normal_y = q[15:0];
            default: r.normal_z = q[15:0];
          endcase
        end
      end
      expected_normals = {expected_normals, r};
    endfunction

    function void check_result(tfn_pkg::tfn_out_t got);
      tfn_pkg::tfn_out_t exp_r;
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = expected_normals.pop_front();
      if (got.normal_x !== exp_r.normal_x || got.normal_y !== exp_r.normal_y ||
          got.normal_z !== exp_r.normal_z || got.degenerate !== exp_r.degenerate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("normal mismatch: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                   exp_r.normal_x, exp_r.normal_y, exp_r.normal_z, exp_r.degenerate,
                   got.normal_x, got.normal_y, got.normal_z, got.degenerate);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  tfn_pkg::tfn_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  tfn_pkg::tfn_out_t out_data;

  normal_scoreboard board;
  int  send_idle_pct = 29;
  int  recv_idle_pct = 64;
  bit  hold_off = 1'b0;
  bit  written[4096];
  int  written_list[$];
  int  stuck_cycles = 0;

  triangle_face_normal_unit dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_transaction(in_data);
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // Watchdog: counts cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= 20000) begin
      $display("triangle_face_normal_unit regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic void note_written(int idx);
    written_list = {written_list, idx};
  endfunction

  // Starts and ends at a falling edge; valid stays up for the next item.
  task automatic send_item(tfn_pkg::tfn_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (t.op == tfn_pkg::OP_WRITE && !written[t.vertex_a]) begin
      written[t.vertex_a] = 1'b1;
      note_written(int'(t.vertex_a));
    end
    @(negedge clk);
  endtask

  task automatic write_vertex(int idx, int x, int y, int z);
    tfn_pkg::tfn_in_t t;
    t = '0;
    t.op = tfn_pkg::OP_WRITE; t.vertex_a = tfn_pkg::IDX_W'(idx);
    t.vertex_b = tfn_pkg::IDX_W'($urandom); t.vertex_c = tfn_pkg::IDX_W'($urandom);
    t.pos_x = tfn_pkg::COORD_W'(x);
    t.pos_y = tfn_pkg::COORD_W'(y);
    t.pos_z = tfn_pkg::COORD_W'(z);
    send_item(t);
  endtask

  task automatic request_normal(int a, int b, int c);
    tfn_pkg::tfn_in_t t;
    t = '0;
    t.op = tfn_pkg::OP_NORMAL;
    t.vertex_a = tfn_pkg::IDX_W'(a);
    t.vertex_b = tfn_pkg::IDX_W'(b);
    t.vertex_c = tfn_pkg::IDX_W'(c);
    // Coordinate fields are ignored for normals but still toggled.
    t.pos_x = tfn_pkg::COORD_W'($urandom);
    t.pos_y = tfn_pkg::COORD_W'($urandom);
    t.pos_z = tfn_pkg::COORD_W'($urandom);
    send_item(t);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(1023) - 512;
      1: return ($urandom_range(1) ? 524287 : -524288);
      default: return $signed($urandom) >>> 12;
    endcase
  endfunction

  function automatic int pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (written_list.size() < 3 || $urandom_range(99) < 40) begin
        write_vertex($urandom_range(4095), rand_coord(), rand_coord(), rand_coord());
      end else if ($urandom_range(99) < 5) begin
        int v;
        v = pick_written();
        request_normal(v, pick_written(), v);
      end else begin
        request_normal(pick_written(), pick_written(), pick_written());
      end
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, degenerate triangles, axis-aligned and index corners.
    write_vertex(0, 0, 0, 0);
    write_vertex(4095, 524287, 524287, 524287);
    write_vertex(1, -524288, -524288, -524288);
    write_vertex(2, 524287, -524288, 0);
    write_vertex(3, 256, 0, 0);
    write_vertex(4, 0, 256, 0);
    write_vertex(5, 0, 0, 256);
    write_vertex(6, -524288, 524287, -1);
    request_normal(0, 3, 4);
    request_normal(0, 4, 3);
    request_normal(0, 5, 3);
    request_normal(0, 0, 0);
    request_normal(0, 4095, 1);
    request_normal(4095, 1, 2);
    request_normal(1, 2, 6);
    request_normal(2, 6, 4095);
    request_normal(3, 4, 5);
    request_normal(3, 3, 5);
    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      run_phase(150);
    join
    run_phase(550);
    send_idle_pct = 64; recv_idle_pct = 29;
    run_phase(530);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_phase(500);
    in_valid <= 1'b0;
    while (board.expected_normals.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("triangle_face_normal_unit regression: pass");
    end else begin
      $display("triangle_face_normal_unit regression: fail");
    end
    $finish;
  end

endmodule
